### sv/jhtd_pkg.sv
`default_nettype none

package jhtd_pkg;

    // Number of code lengths carried by a DHT table, and the width of an index into them.
    localparam int NUM_LENGTHS = 16;
    localparam int CNT_IW      = 4;
    // Width of a code length in the range 1..16.
    localparam int LEN_W       = 5;
    localparam int BYTE_W      = 8;

    typedef enum logic [1:0] {
        REQ_NEW    = 2'd0,
        REQ_LOAD   = 2'd1,
        REQ_DECODE = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_PLACE = 1'b1
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic place;
        logic decode;
    } t_cmd;

    typedef struct packed {
        logic count_phase;
    } t_stat;

endpackage

`default_nettype wire

### sv/jhtd_ctrl.sv
`default_nettype none

module jhtd_ctrl
    import jhtd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [1:0]        i_req_type,
    input  wire t_stat             i_stat,
    output t_cmd                   o_cmd,
    output logic                   o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (t_req'(i_req_type))
                        REQ_NEW: begin
                            o_cmd.clear = 1'b1;
                        end
                        REQ_LOAD: begin
                            o_cmd.load = 1'b1;
                            // A count beat goes on to the placement state to finish code placement.
                            if (i_stat.count_phase) begin
                                n_state = S_PLACE;
                            end
                        end
                        REQ_DECODE: begin
                            o_cmd.decode = 1'b1;
                        end
                        REQ_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PLACE: begin
                o_busy      = 1'b1;
                o_cmd.place = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_place_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLACE) |=> (r_state == S_IDLE))
        else $error("placement state held longer than one cycle");

endmodule

`default_nettype wire

### sv/jhtd_datapath.sv
`default_nettype none

module jhtd_datapath
    import jhtd_pkg::*;
#(
    parameter int MAX_SYMBOLS     = 256,
    parameter int MAX_CODE_LENGTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    input  wire logic [BYTE_W-1:0] i_table_byte,
    input  wire logic              i_code_bit,
    output logic                   o_valid,
    output logic [BYTE_W-1:0]      o_symbol,
    output logic                   o_status
);

    localparam int CW  = MAX_CODE_LENGTH;
    localparam int FW  = CW + 1;
    localparam int FW1 = FW + 1;
    localparam int FW2 = FW + 2;
    localparam int LW  = $clog2(CW);
    localparam int LNW = $clog2(CW + 1);
    localparam int AW  = $clog2(MAX_SYMBOLS);
    localparam int BW  = AW + 1;
    localparam int IW  = ((BW > BYTE_W) ? BW : BYTE_W) + 1;
    localparam int PW  = $clog2(NUM_LENGTHS + MAX_SYMBOLS + 1);
    localparam logic [FW-1:0] FCAP = {FW{1'b1}};
    localparam logic [BW-1:0] BCAP = {BW{1'b1}};

    logic [BYTE_W-1:0] r_counts [NUM_LENGTHS];
    logic [BYTE_W-1:0] r_mem    [MAX_SYMBOLS];

    logic [PW-1:0]     r_pos,      n_pos;
    logic [CW-1:0]     r_code,     n_code;
    logic [LW-1:0]     r_len,      n_len;
    logic [FW-1:0]     r_first,    n_first;
    logic [BW-1:0]     r_base,     n_base;
    logic [FW-1:0]     r_plan,     n_plan;
    logic [CW-1:0]     r_last,     n_last;
    logic              r_has,      n_has;
    logic [CW-1:0]     r_pl_last,  n_pl_last;
    logic [LNW-1:0]    r_pl_shift, n_pl_shift;
    logic              r_pl_any,   n_pl_any;
    logic              r_out_valid, n_out_valid;
    logic              r_out_status, n_out_status;
    logic [BYTE_W-1:0] r_rd_data;

    logic              count_phase;
    logic              sym_ok;
    logic [PW-1:0]     sym_pos;
    logic              cnt_we;
    logic              mem_we;
    logic              rd_en;

    // Placement of one count, first half.
    logic [LEN_W-1:0]  pl_len;
    logic              pl_len_ok;
    logic [FW-1:0]     pl_pow;
    logic              pl_fit;
    logic [FW-1:0]     pl_room;
    logic [FW-1:0]     pl_placed;
    logic [FW-1:0]     pl_last_full;
    logic [LNW-1:0]    pl_shift;
    logic [FW1-1:0]    plan_sum;
    logic [FW2-1:0]    plan_dbl;
    logic [FW-1:0]     plan_next;

    // One code bit.
    logic [LNW-1:0]    len;
    logic [CW-1:0]     code;
    logic [BYTE_W-1:0] cnt;
    logic [FW-1:0]     code_f;
    logic [FW-1:0]     diff;
    logic              hit;
    logic [IW-1:0]     idx;
    logic              idx_ok;
    logic [CW-1:0]     lim;
    logic              more;
    logic [IW-1:0]     base_sum;
    logic [BW-1:0]     base_next;
    logic [FW1-1:0]    first_sum;
    logic [FW2-1:0]    first_dbl;
    logic [FW-1:0]     first_next;

    assign count_phase        = (r_pos < PW'(NUM_LENGTHS));
    assign sym_pos            = r_pos - PW'(NUM_LENGTHS);
    assign sym_ok             = (sym_pos < PW'(MAX_SYMBOLS));
    assign o_stat.count_phase = count_phase;

    assign pl_len       = LEN_W'(r_pos[CNT_IW-1:0]) + LEN_W'(1);
    assign pl_len_ok    = (pl_len <= LEN_W'(CW));
    assign pl_pow       = FW'(1) << pl_len;
    assign pl_fit       = (r_plan < pl_pow);
    assign pl_room      = pl_pow - r_plan;
    assign pl_placed    = (FW'(i_table_byte) < pl_room) ? FW'(i_table_byte) : pl_room;
    assign pl_last_full = r_plan + pl_placed - FW'(1);
    assign pl_shift     = LNW'(LEN_W'(CW) - pl_len);
    assign plan_sum     = FW1'(r_plan) + FW1'(i_table_byte);
    assign plan_dbl     = {plan_sum, 1'b0};
    assign plan_next    = (plan_dbl > FW2'(FCAP)) ? FCAP : plan_dbl[FW-1:0];

    assign len        = LNW'(r_len) + LNW'(1);
    assign code       = {r_code[CW-2:0], i_code_bit};
    assign cnt        = r_counts[CNT_IW'(r_len)];
    assign code_f     = FW'(code);
    assign diff       = code_f - r_first;
    assign hit        = (code_f >= r_first) && (diff < FW'(cnt));
    assign idx        = IW'(r_base) + IW'(diff[BYTE_W-1:0]);
    assign idx_ok     = (idx < IW'(MAX_SYMBOLS));
    // Largest prefix of this length that still leads to a placed code.
    assign lim        = r_last >> (LNW'(CW) - len);
    assign more       = (len < LNW'(CW)) && r_has && (code <= lim);
    assign base_sum   = IW'(r_base) + IW'(cnt);
    assign base_next  = (base_sum > IW'(BCAP)) ? BCAP : base_sum[BW-1:0];
    assign first_sum  = FW1'(r_first) + FW1'(cnt);
    assign first_dbl  = {first_sum, 1'b0};
    assign first_next = (first_dbl > FW2'(FCAP)) ? FCAP : first_dbl[FW-1:0];

    always_comb begin
        n_pos        = r_pos;
        n_code       = r_code;
        n_len        = r_len;
        n_first      = r_first;
        n_base       = r_base;
        n_plan       = r_plan;
        n_last       = r_last;
        n_has        = r_has;
        n_pl_last    = r_pl_last;
        n_pl_shift   = r_pl_shift;
        n_pl_any     = r_pl_any;
        n_out_valid  = 1'b0;
        n_out_status = 1'b1;
        cnt_we       = 1'b0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        if (i_cmd.clear) begin
            n_pos   = '0;
            n_code  = '0;
            n_len   = '0;
            n_first = '0;
            n_base  = '0;
            n_plan  = '0;
            n_last  = '0;
            n_has   = 1'b0;
        end else if (i_cmd.load) begin
            if (count_phase) begin
                cnt_we     = 1'b1;
                n_pos      = r_pos + PW'(1);
                n_pl_last  = pl_last_full[CW-1:0];
                n_pl_shift = pl_shift;
                n_pl_any   = pl_len_ok && pl_fit && (pl_placed != '0);
                if (pl_len_ok) begin
                    n_plan = plan_next;
                end
            end else if (sym_ok) begin
                mem_we = 1'b1;
                n_pos  = r_pos + PW'(1);
            end
        end else if (i_cmd.place) begin
            if (r_pl_any) begin
                n_last = CW'(r_pl_last << r_pl_shift);
                n_has  = 1'b1;
            end
        end else if (i_cmd.decode) begin
            n_out_valid = 1'b1;
            n_code      = '0;
            n_len       = '0;
            n_first     = '0;
            n_base      = '0;
            if (!count_phase) begin
                if (hit) begin
                    if (idx_ok) begin
                        rd_en        = 1'b1;
                        n_out_status = 1'b0;
                    end
                end else if (more) begin
                    n_out_valid = 1'b0;
                    n_code      = code;
                    n_len       = LW'(len);
                    n_first     = first_next;
                    n_base      = base_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_code      <= '0;
            r_len       <= '0;
            r_first     <= '0;
            r_base      <= '0;
            r_plan      <= '0;
            r_last      <= '0;
            r_has       <= 1'b0;
            r_pl_any    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_code      <= n_code;
            r_len       <= n_len;
            r_first     <= n_first;
            r_base      <= n_base;
            r_plan      <= n_plan;
            r_last      <= n_last;
            r_has       <= n_has;
            r_pl_any    <= n_pl_any;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pl_last    <= n_pl_last;
        r_pl_shift   <= n_pl_shift;
        r_out_status <= n_out_status;
        if (cnt_we) begin
            r_counts[r_pos[CNT_IW-1:0]] <= i_table_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[sym_pos[AW-1:0]] <= i_table_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[idx[AW-1:0]];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_symbol = r_out_status ? '0 : r_rd_data;

    a_valid_from_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(i_cmd.decode))
        else $error("result beat without a decode request");

    a_result_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_len == '0) && (r_code == '0) && (r_base == '0))
        else $error("code state not restarted after a result");

    a_place_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.place |-> $past(i_cmd.load))
        else $error("placement step without a preceding count load");

endmodule

`default_nettype wire

### sv/jpeg_huffman_table_decoder.sv
`default_nettype none

// JPEG canonical Huffman decoder with an in-block DHT table.
// Requests enter on start when busy is low, with i_req_type selecting the
// operation: start a new table, load one table byte, or decode one stream bit
// (most significant first). A table is sixteen length counts followed by up to
// MAX_SYMBOLS symbol bytes; extra bytes are dropped.
// Symbol bytes, new-table requests and decode bits never raise busy, so the
// stream is consumed at one bit per clock while busy is low. A count byte is
// followed by a placement step that finishes placing the codes of that length,
// and busy is high in it. A decode bit that completes a code, or that cannot
// lead to any code, gives one result beat on o_valid in the cycle after the
// bit is taken, with o_symbol and o_status (0 symbol decoded, 1 invalid code,
// symbol then reads zero). The symbol memory read is registered.
// The receiver cannot stall: each beat is shown for exactly one cycle.
// Reset clears the load position, the code state and the placement tracker;
// no clearing pass runs, so the block takes requests right after reset.
// Counts and symbols must be loaded before they are decoded.

module jpeg_huffman_table_decoder
    import jhtd_pkg::*;
#(
    parameter int MAX_SYMBOLS     = 256,
    parameter int MAX_CODE_LENGTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_req_type,
    input  wire logic [BYTE_W-1:0] i_table_byte,
    input  wire logic              i_code_bit,
    output logic                   o_valid,
    output logic [BYTE_W-1:0]      o_symbol,
    output logic                   o_status
);

    t_cmd  cmd;
    t_stat stat;

    jhtd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    jhtd_datapath #(
        .MAX_SYMBOLS     (MAX_SYMBOLS),
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_table_byte (i_table_byte),
        .i_code_bit   (i_code_bit),
        .o_valid      (o_valid),
        .o_symbol     (o_symbol),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire

### tb/jpeg_huffman_table_decoder_tb.sv
module jpeg_huffman_table_decoder_tb
    import jhtd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SYMBOLS = 256;
    localparam int MAX_LEN     = 16;
    localparam int LOAD_END    = NUM_LENGTHS + MAX_SYMBOLS;
    localparam int ITEM_TARGET = 1350;

    typedef struct {
        logic [7:0] symbol;
        logic       status;
    } t_decode_result;

    typedef struct {
        int unsigned code;
        int unsigned len;
    } t_code;

    typedef enum int {
        TBL_CANONICAL,
        TBL_OVERSUBSCRIBED,
        TBL_EMPTY,
        TBL_PARTIAL
    } t_table_kind;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       start        = 1'b0;
    logic [1:0] i_req_type   = REQ_NOP;
    logic [7:0] i_table_byte = 8'd0;
    logic       i_code_bit   = 1'b0;
    logic       busy;
    logic       o_valid;
    logic [7:0] o_symbol;
    logic       o_status;

    jpeg_huffman_table_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_table_byte (i_table_byte),
        .i_code_bit   (i_code_bit),
        .o_valid      (o_valid),
        .o_symbol     (o_symbol),
        .o_status     (o_status)
    );

    // Mirror of the decoder's table and code state.
    logic [7:0]  len_count [NUM_LENGTHS];
    logic [7:0]  sym_table [MAX_SYMBOLS];
    bit          sym_loaded [MAX_SYMBOLS];
    int unsigned load_ptr;
    int unsigned code_acc;
    int unsigned code_len;
    int unsigned len_first;
    int unsigned len_base;
    int unsigned plan_next;
    int unsigned plan_last;
    bit          plan_any;

    t_decode_result pending_symbols [$];
    t_code          code_list [$];
    logic [7:0]     tbl_counts [NUM_LENGTHS];

    int  errors    = 0;
    int  n_items   = 0;
    int  n_results = 0;
    int  n_invalid = 0;
    int  n_tables  = 0;
    bit  quiet     = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("jpeg_huffman_table_decoder_tb failed");
        $finish;
    end

    function automatic int unsigned clip(input int unsigned v, input int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic void restart_code();
        code_acc  = 0;
        code_len  = 0;
        len_first = 0;
        len_base  = 0;
    endfunction

    function automatic void reset_model();
        load_ptr  = 0;
        plan_next = 0;
        plan_last = 0;
        plan_any  = 1'b0;
        restart_code();
        foreach (sym_loaded[i]) sym_loaded[i] = 1'b0;
    endfunction

    // Tracks where the last code of each length lands, so a prefix can be
    // told apart from a dead branch.
    function automatic void place_length(input int unsigned l, input int unsigned c);
        int unsigned room;
        int unsigned placed;
        if (plan_next < (1 << l)) begin
            room   = (1 << l) - plan_next;
            placed = (c < room) ? c : room;
            if (placed != 0) begin
                plan_last = ((plan_next + placed - 1) << (MAX_LEN - l)) & 32'hFFFF;
                plan_any  = 1'b1;
            end
        end
        plan_next = clip((plan_next + c) << 1, 32'h1FFFF);
    endfunction

    // Symbol slot that a decode bit would read, or -1 when it reads none.
    function automatic int slot_hit(input logic b);
        int unsigned ln;
        int unsigned cd;
        int unsigned ix;
        if (load_ptr < NUM_LENGTHS) return -1;
        ln = code_len + 1;
        cd = ((code_acc << 1) | b) & 32'hFFFF;
        if (cd >= len_first && cd - len_first < len_count[ln-1]) begin
            ix = len_base + cd - len_first;
            if (ix < MAX_SYMBOLS) return ix;
        end
        return -1;
    endfunction

    function automatic void predict_request(input t_req req, input logic [7:0] tbyte,
                                            input logic cbit);
        int unsigned    ln;
        int unsigned    cd;
        int unsigned    ct;
        int unsigned    ix;
        bit             emit;
        t_decode_result r;
        case (req)
            REQ_NEW: begin
                load_ptr  = 0;
                plan_next = 0;
                plan_last = 0;
                plan_any  = 1'b0;
                restart_code();
            end
            REQ_LOAD: begin
                if (load_ptr < NUM_LENGTHS) begin
                    len_count[load_ptr] = tbyte;
                    place_length(load_ptr + 1, 32'(tbyte));
                    load_ptr++;
                end else if (load_ptr < LOAD_END) begin
                    sym_table[load_ptr - NUM_LENGTHS]  = tbyte;
                    sym_loaded[load_ptr - NUM_LENGTHS] = 1'b1;
                    load_ptr++;
                end
            end
            REQ_DECODE: begin
                r.symbol = 8'd0;
                r.status = 1'b1;
                emit     = 1'b1;
                if (load_ptr < NUM_LENGTHS) begin
                    restart_code();
                end else begin
                    ln = code_len + 1;
                    cd = ((code_acc << 1) | cbit) & 32'hFFFF;
                    ct = 32'(len_count[ln-1]);
                    if (cd >= len_first && cd - len_first < ct) begin
                        ix = len_base + cd - len_first;
                        if (ix < MAX_SYMBOLS) begin
                            r.symbol = sym_table[ix];
                            r.status = 1'b0;
                        end
                        restart_code();
                    end else if (ln < MAX_LEN && plan_any &&
                                 cd <= (plan_last >> (MAX_LEN - ln))) begin
                        len_base  = clip(len_base + ct, 511);
                        len_first = clip((len_first + ct) << 1, 32'h1FFFF);
                        code_acc  = cd;
                        code_len  = ln;
                        emit      = 1'b0;
                    end else begin
                        restart_code();
                    end
                end
                if (emit) pending_symbols.insert(pending_symbols.size(), r);
            end
            default: ;
        endcase
    endfunction

    // Canonical codes of the table in tbl_counts, in symbol order.
    function automatic void list_codes();
        int unsigned nxt;
        int unsigned n;
        t_code       cc;
        nxt = 0;
        code_list.delete();
        for (int l = 1; l <= MAX_LEN; l++) begin
            if (nxt < (1 << l)) begin
                n = clip(32'(tbl_counts[l-1]), (1 << l) - nxt);
                for (int k = 0; k < n; k++) begin
                    cc.code = nxt + k;
                    cc.len  = l;
                    code_list.insert(code_list.size(), cc);
                end
            end
            nxt = clip((nxt + tbl_counts[l-1]) << 1, 32'h1FFFF);
        end
    endfunction

    function automatic void plan_table(input t_table_kind kind);
        int unsigned open_slots;
        int unsigned budget;
        int unsigned lim;
        int unsigned c;
        int unsigned top;
        top        = ($urandom_range(99) < 20) ? $urandom_range(16, 9) : $urandom_range(8, 1);
        budget     = ($urandom_range(99) < 10) ? $urandom_range(120, 30) : $urandom_range(20, 1);
        open_slots = 1;
        for (int l = 0; l < NUM_LENGTHS; l++) begin
            tbl_counts[l] = 8'd0;
            if (kind != TBL_EMPTY && l < top && open_slots != 0 && budget != 0) begin
                open_slots = (open_slots > 2048) ? 4096 : open_slots * 2;
                lim = clip(clip(open_slots, 255), budget);
                if (l == top - 1 && $urandom_range(99) < 80) c = lim;
                else if ($urandom_range(1)) c = $urandom_range(lim);
                else c = 0;
                tbl_counts[l] = 8'(c);
                open_slots -= c;
                budget     -= c;
            end
        end
        if (kind == TBL_OVERSUBSCRIBED) begin
            repeat ($urandom_range(3, 1)) tbl_counts[$urandom_range(15)] = 8'($urandom_range(255));
        end
    endfunction

    // One beat: optional idle gap, then hold start until busy drops.
    task automatic send_item(input t_req req, input logic [7:0] tbyte, input logic cbit);
        if (!quiet && $urandom_range(99) < 8) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= req;
        i_table_byte <= tbyte;
        i_code_bit   <= cbit;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_request(req, tbyte, cbit);
        if (req != REQ_NOP) n_items++;
    endtask

    // A symbol slot must be loaded before a code reads it; load more symbols
    // of the current table until it is.
    task automatic send_bit(input logic b);
        while (load_ptr < LOAD_END && slot_hit(b) >= 0 && !sym_loaded[slot_hit(b)])
            send_item(REQ_LOAD, 8'($urandom_range(255)), 1'($urandom_range(1)));
        send_item(REQ_DECODE, 8'($urandom_range(255)), b);
    endtask

    task automatic send_code(input t_code c);
        for (int k = c.len - 1; k >= 0; k--) send_bit(c.code[k]);
    endtask

    task automatic load_counts(input int ncnt);
        send_item(REQ_NEW, 8'($urandom_range(255)), 1'($urandom_range(1)));
        for (int i = 0; i < ncnt; i++) send_item(REQ_LOAD, tbl_counts[i], 1'($urandom_range(1)));
        list_codes();
        n_tables++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_symbols.size() != 0);
    endtask

    task automatic test_decode_without_table();
        send_item(REQ_NEW, 8'h00, 1'b0);
        send_bit(1'b0);
        send_bit(1'b1);
        send_item(REQ_NOP, 8'hFF, 1'b1);
    endtask

    // One code of length one and an oversubscribed count of 255 at length
    // two, of which only two codes fit.
    task automatic test_small_table();
        foreach (tbl_counts[i]) tbl_counts[i] = 8'd0;
        tbl_counts[0] = 8'd1;
        tbl_counts[1] = 8'd255;
        load_counts(NUM_LENGTHS);
        send_item(REQ_LOAD, 8'hFF, 1'b1);
        send_item(REQ_LOAD, 8'h00, 1'b0);
        send_item(REQ_LOAD, 8'hA5, 1'b1);
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b1);
    endtask

    // Full symbol store plus bytes past its end; the last length-9 code
    // maps beyond the store and must decode as invalid.
    task automatic test_full_table();
        foreach (tbl_counts[i]) tbl_counts[i] = 8'd0;
        tbl_counts[7] = 8'd255;
        tbl_counts[8] = 8'd2;
        load_counts(NUM_LENGTHS);
        repeat (MAX_SYMBOLS + 4)
            send_item(REQ_LOAD, 8'($urandom_range(255)), 1'($urandom_range(1)));
        send_code(code_list[code_list.size() - 1]);
        send_code(code_list[code_list.size() - 2]);
        send_code(code_list[0]);
        repeat (10) send_code(code_list[$urandom_range(code_list.size() - 1)]);
    endtask

    task automatic test_random_tables();
        t_table_kind kind;
        int          pick;
        int          total;
        int          nsym;
        int          ncnt;
        int          round;
        round = 0;
        while (n_items < ITEM_TARGET) begin
            quiet = (round >= 6 && round < 12);
            if (round == 4) drain_results();
            pick = $urandom_range(99);
            kind = (pick < 65) ? TBL_CANONICAL :
                   (pick < 80) ? TBL_OVERSUBSCRIBED :
                   (pick < 88) ? TBL_EMPTY : TBL_PARTIAL;
            plan_table(kind);
            ncnt = (kind == TBL_PARTIAL) ? $urandom_range(15) : NUM_LENGTHS;
            load_counts(ncnt);
            total = 0;
            foreach (tbl_counts[i]) total += tbl_counts[i];
            nsym = ($urandom_range(99) < 70) ? total : $urandom_range(total);
            if (nsym > 48) nsym = 48;
            if (kind == TBL_PARTIAL) nsym = 0;
            repeat (nsym) send_item(REQ_LOAD, 8'($urandom_range(255)), 1'($urandom_range(1)));
            repeat ($urandom_range(14, 3)) begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    send_item(REQ_NOP, 8'($urandom_range(255)), 1'($urandom_range(1)));
                end else if (pick < 20 || code_list.size() == 0) begin
                    repeat ($urandom_range(4, 1)) send_bit(1'($urandom_range(1)));
                end else begin
                    while (code_len != 0) send_bit(1'($urandom_range(1)));
                    send_code(code_list[$urandom_range(code_list.size() - 1)]);
                end
            end
            // Sometimes leave a code half done when the next table starts.
            if ($urandom_range(99) < 30)
                repeat ($urandom_range(3, 1)) send_bit(1'($urandom_range(1)));
            round++;
        end
        quiet = 1'b0;
    endtask

    always @(posedge i_clk) begin : check_results
        t_decode_result want;
        if (i_rst_n && o_valid) begin
            if (pending_symbols.size() == 0) begin
                $error("unexpected result beat: symbol %0d status %0d", o_symbol, o_status);
                errors++;
            end else begin
                want = pending_symbols.pop_front();
                n_results++;
                if (want.status) n_invalid++;
                if (o_symbol !== want.symbol) begin
                    $error("symbol: expected %0d, got %0d", want.symbol, o_symbol);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
            end
        end
    end

    initial begin
        int waited;
        waited = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        reset_model();
        @(posedge i_clk);
        test_decode_without_table();
        test_small_table();
        test_full_table();
        test_random_tables();
        start <= 1'b0;
        while (pending_symbols.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_symbols.size() != 0) begin
            $error("%0d decode results never arrived", pending_symbols.size());
            errors++;
        end
        $display("Sent %0d requests over %0d tables; checked %0d decode results, %0d invalid.",
                 n_items, n_tables, n_results, n_invalid);
        if (errors == 0) begin
            $display("jpeg_huffman_table_decoder_tb passed");
        end else begin
            $display("jpeg_huffman_table_decoder_tb failed");
        end
        $finish;
    end

endmodule
